FILE: src/cau_pkg.sv
`default_nettype none
package cau_pkg;
    localparam int DATA_W = 32;
    localparam int FRAC_BITS_DEF = 16;
    localparam int MAG_W = 64;

    typedef enum logic [2:0] {
        FN_ADD = 3'd0,
        FN_SUB = 3'd1,
        FN_MUL = 3'd2,
        FN_DIV = 3'd3,
        FN_MAG = 3'd4
    } t_func;

    typedef enum logic [1:0] {
        ST_OK   = 2'd0,
        ST_OVF  = 2'd1,
        ST_DIVZ = 2'd2
    } t_status;

    typedef struct packed {
        logic [2:0]              func;
        logic signed [DATA_W-1:0] a_re;
        logic signed [DATA_W-1:0] a_im;
        logic signed [DATA_W-1:0] b_re;
        logic signed [DATA_W-1:0] b_im;
    } t_in;

    typedef struct packed {
        logic signed [DATA_W-1:0] res_re;
        logic signed [DATA_W-1:0] res_im;
        logic [1:0]               status;
    } t_out;

    // Sign and magnitude to a saturated 32-bit word; bit 32 of the result flags overflow.
    function automatic logic [DATA_W:0] sat_sm(input logic neg, input logic [MAG_W:0] mag);
        logic [DATA_W:0] r;
        if (!neg) begin
            if (mag > {{(MAG_W-DATA_W+2){1'b0}}, {(DATA_W-1){1'b1}}})
                r = {1'b1, 1'b0, {(DATA_W-1){1'b1}}};
            else
                r = {1'b0, mag[DATA_W-1:0]};
        end else begin
            if (mag > {{(MAG_W-DATA_W+1){1'b0}}, 1'b1, {(DATA_W-1){1'b0}}})
                r = {1'b1, 1'b1, {(DATA_W-1){1'b0}}};
            else
                r = {1'b0, DATA_W'(-mag[DATA_W-1:0])};
        end
        return r;
    endfunction
endpackage
`default_nettype wire

FILE: src/cau_if.sv
`default_nettype none
interface cau_if #(parameter type t_payload = logic) ();
    logic     valid;
    logic     ready;
    t_payload data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

FILE: src/cau_div.sv
`default_nettype none
// Pipelined restoring divider: one quotient bit per stage, magnitudes only.
module cau_div
    import cau_pkg::*;
#(
    parameter int NUM_W = 96,
    parameter int DEN_W = 64,
    parameter int Q_W   = 41
) (
    input  wire logic              i_clk,
    input  wire logic              i_en,
    input  wire logic [NUM_W-1:0]  i_num,
    input  wire logic [DEN_W-1:0]  i_den,
    output logic [Q_W-1:0]         o_quo,
    output logic                   o_big
);
    // Quotient has NUM_W bits; only the low Q_W-1 matter, anything above saturates.
    logic [NUM_W-1:0] r_num [NUM_W+1];
    logic [DEN_W:0]   r_rem [NUM_W+1];
    logic [DEN_W-1:0] r_den [NUM_W+1];

    always_comb begin
        r_num[0] = i_num;
        r_rem[0] = '0;
        r_den[0] = i_den;
    end

    for (genvar k = 0; k < NUM_W; k++) begin : g_st
        logic [DEN_W:0] n_sh;
        logic [DEN_W:0] n_sub;
        always_comb begin
            n_sh  = {r_rem[k][DEN_W-1:0], r_num[k][NUM_W-1]};
            n_sub = n_sh - {1'b0, r_den[k]};
        end
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                if (!n_sub[DEN_W] || r_rem[k][DEN_W]) begin
                    r_rem[k+1] <= n_sub;
                    r_num[k+1] <= {r_num[k][NUM_W-2:0], 1'b1};
                end else begin
                    r_rem[k+1] <= n_sh;
                    r_num[k+1] <= {r_num[k][NUM_W-2:0], 1'b0};
                end
                r_den[k+1] <= r_den[k];
            end
        end
    end

    assign o_quo = {1'b0, r_num[NUM_W][Q_W-2:0]};
    assign o_big = |r_num[NUM_W][NUM_W-1:Q_W-1];
endmodule
`default_nettype wire

FILE: src/complex_arithmetic_unit.sv
// Path: operand, product, sum and stage-4 registers, the divider stages, then the output register.
// Throughput: one item per cycle while the output is not stalled; every operation flows through the same pipeline.
// The pipeline holds as a whole while the output is stalled; no item is lost.
// Reset (i_rst_n low, synchronous) clears all valid bits; payloads keep their values.
`default_nettype none
module complex_arithmetic_unit
    import cau_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEF
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    cau_if.sink       i_in,
    cau_if.source     o_out
);
    localparam int NUM_W = MAG_W + 32;
    localparam int DLAT  = NUM_W;
    localparam int LAT   = 4 + DLAT;

    logic en;
    logic r_v [LAT+1];
    logic r_ovalid;

    // The whole pipe advances unless the output register holds an untaken item.
    assign en = !r_ovalid || o_out.ready;
    assign i_in.ready = en;

    // Stage 1: register operands
    t_in r_s1;
    always_ff @(posedge i_clk) if (en) r_s1 <= i_in.data;

    // Stage 2: four products and add/sub sums
    logic signed [63:0] r_p_rr, r_p_ii, r_p_ri, r_p_ir;
    logic signed [DATA_W:0] r_sr, r_si;
    logic [2:0] r_f2;
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_f2 <= r_s1.func;
            r_p_rr <= r_s1.func == FN_MAG ? r_s1.a_re * r_s1.a_re : r_s1.a_re * r_s1.b_re;
            r_p_ii <= r_s1.func == FN_MAG ? r_s1.a_im * r_s1.a_im : r_s1.a_im * r_s1.b_im;
            r_p_ri <= r_s1.a_re * r_s1.b_im;
            r_p_ir <= r_s1.a_im * r_s1.b_re;
            r_sr <= r_s1.func == FN_SUB ? r_s1.a_re - r_s1.b_re : r_s1.a_re + r_s1.b_re;
            r_si <= r_s1.func == FN_SUB ? r_s1.a_im - r_s1.b_im : r_s1.a_im + r_s1.b_im;
        end
    end

    // Stage 3: sums of products in 65-bit signed form, denominator
    logic signed [64:0] r_xr, r_xi;
    logic [MAG_W-1:0] n_den;
    logic signed [DATA_W:0] r_sr3, r_si3;
    logic [2:0] r_f3;
    logic signed [63:0] r_bb_rr, r_bb_ii;
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_f3 <= r_f2;
            r_sr3 <= r_sr;
            r_si3 <= r_si;
            case (r_f2)
                FN_DIV: begin
                    r_xr <= 65'(r_p_rr) + 65'(r_p_ii);
                    r_xi <= 65'(r_p_ir) - 65'(r_p_ri);
                end
                FN_MUL: begin
                    r_xr <= 65'(r_p_rr) - 65'(r_p_ii);
                    r_xi <= 65'(r_p_ri) + 65'(r_p_ir);
                end
                default: begin
                    r_xr <= 65'(r_p_rr) + 65'(r_p_ii);
                    r_xi <= '0;
                end
            endcase
        end
    end

    // Denominator products computed in a parallel stage-2 register pair
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_bb_rr <= r_s1.b_re * r_s1.b_re;
            r_bb_ii <= r_s1.b_im * r_s1.b_im;
        end
    end
    always_comb n_den = MAG_W'(r_bb_rr) + MAG_W'(r_bb_ii);

    logic [MAG_W-1:0] r_den3;
    always_ff @(posedge i_clk) if (en) r_den3 <= n_den;

    // Stage 4: sign/magnitude, direct results, divider inputs
    logic n_nr, n_ni;
    logic [MAG_W:0] n_mr, n_mi;
    always_comb begin
        n_nr = r_xr[64];
        n_ni = r_xi[64];
        n_mr = n_nr ? 65'(-r_xr) : 65'(r_xr);
        n_mi = n_ni ? 65'(-r_xi) : 65'(r_xi);
    end

    logic [MAG_W:0] n_fr, n_fi;
    logic [DATA_W:0] n_dre, n_dim;
    logic [1:0] n_dst;
    always_comb begin
        n_fr = n_nr ? (n_mr + 65'((66'd1 << FRAC_BITS) - 1)) >> FRAC_BITS : n_mr >> FRAC_BITS;
        n_fi = n_ni ? (n_mi + 65'((66'd1 << FRAC_BITS) - 1)) >> FRAC_BITS : n_mi >> FRAC_BITS;
        n_dre = '0;
        n_dim = '0;
        n_dst = ST_OK;
        case (r_f3)
            FN_ADD, FN_SUB: begin
                n_dre = sat_sm(r_sr3[DATA_W], r_sr3[DATA_W] ? 65'(-r_sr3) : 65'(r_sr3));
                n_dim = sat_sm(r_si3[DATA_W], r_si3[DATA_W] ? 65'(-r_si3) : 65'(r_si3));
            end
            FN_MUL: begin
                n_dre = sat_sm(n_nr && n_fr != 0, n_fr);
                n_dim = sat_sm(n_ni && n_fi != 0, n_fi);
            end
            FN_MAG: begin
                n_dre = sat_sm(n_nr && n_fr != 0, n_fr);
            end
            default: ;
        endcase
        if (n_dre[DATA_W] || n_dim[DATA_W]) n_dst = ST_OVF;
    end

    t_out r_d4;
    logic [2:0] r_f4;
    logic r_nr4, r_ni4, r_dz4;
    logic [NUM_W-1:0] r_numr, r_numi;
    logic [MAG_W-1:0] r_den4;
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_d4 <= '{res_re: n_dre[DATA_W-1:0], res_im: n_dim[DATA_W-1:0], status: n_dst};
            r_f4 <= r_f3;
            r_nr4 <= n_nr;
            r_ni4 <= n_ni;
            r_dz4 <= r_den3 == '0;
            r_numr <= NUM_W'(n_mr) << FRAC_BITS;
            r_numi <= NUM_W'(n_mi) << FRAC_BITS;
            r_den4 <= r_den3 == '0 ? MAG_W'(1) : r_den3;
        end
    end

    logic [40:0] w_qr, w_qi;
    logic w_br, w_bi;
    cau_div #(.NUM_W(NUM_W), .DEN_W(MAG_W), .Q_W(41)) u_div_re (
        .i_clk(i_clk), .i_en(en), .i_num(r_numr), .i_den(r_den4), .o_quo(w_qr), .o_big(w_br));
    cau_div #(.NUM_W(NUM_W), .DEN_W(MAG_W), .Q_W(41)) u_div_im (
        .i_clk(i_clk), .i_en(en), .i_num(r_numi), .i_den(r_den4), .o_quo(w_qi), .o_big(w_bi));

    // Side band alongside the divider
    t_out r_db [DLAT+1];
    logic [2:0] r_fb [DLAT+1];
    logic r_nrb [DLAT+1];
    logic r_nib [DLAT+1];
    logic r_dzb [DLAT+1];
    always_comb begin
        r_db[0] = r_d4;
        r_fb[0] = r_f4;
        r_nrb[0] = r_nr4;
        r_nib[0] = r_ni4;
        r_dzb[0] = r_dz4;
    end
    for (genvar k = 0; k < DLAT; k++) begin : g_sb
        always_ff @(posedge i_clk) begin
            if (en) begin
                r_db[k+1] <= r_db[k];
                r_fb[k+1] <= r_fb[k];
                r_nrb[k+1] <= r_nrb[k];
                r_nib[k+1] <= r_nib[k];
                r_dzb[k+1] <= r_dzb[k];
            end
        end
    end

    logic [MAG_W:0] n_qr, n_qi;
    logic [DATA_W:0] n_vr, n_vi;
    t_out n_out;
    always_comb begin
        n_qr = w_br ? 65'h1_0000_0000 : 65'(w_qr);
        n_qi = w_bi ? 65'h1_0000_0000 : 65'(w_qi);
        n_vr = sat_sm(r_nrb[DLAT] && n_qr != 0, n_qr);
        n_vi = sat_sm(r_nib[DLAT] && n_qi != 0, n_qi);
        n_out = r_db[DLAT];
        if (r_fb[DLAT] == FN_DIV) begin
            if (r_dzb[DLAT]) begin
                n_out = '{res_re: '0, res_im: '0, status: ST_DIVZ};
            end else begin
                n_out.res_re = n_vr[DATA_W-1:0];
                n_out.res_im = n_vi[DATA_W-1:0];
                n_out.status = (n_vr[DATA_W] || n_vi[DATA_W]) ? ST_OVF : ST_OK;
            end
        end
    end

    // Valid bits
    for (genvar k = 0; k < LAT; k++) begin : g_v
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) r_v[k+1] <= 1'b0;
            else if (en) r_v[k+1] <= r_v[k];
        end
    end
    assign r_v[0] = i_in.valid;

    t_out r_out;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (en) begin
            r_ovalid <= r_v[LAT];
        end
    end
    always_ff @(posedge i_clk) if (en) r_out <= n_out;

    assign o_out.valid = r_ovalid;
    assign o_out.data  = r_out;

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ovalid && !o_out.ready |=> r_ovalid && $stable(r_out))
        else $error("output item changed while stalled");
    a_rdy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_ovalid |-> i_in.ready)
        else $error("pipe stalled with empty output");
    a_divz: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ovalid && r_out.status == ST_DIVZ |-> r_out.res_re == 0 && r_out.res_im == 0)
        else $error("divide by zero result not cleared");
    a_stat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ovalid |-> r_out.status <= ST_DIVZ)
        else $error("bad status code");
endmodule
`default_nettype wire

FILE: test/tb_complex_arithmetic_unit.sv
`timescale 1ns / 1ps
module tb_complex_arithmetic_unit
    import cau_pkg::*;
();

    localparam logic [2:0] FN_RSVD5 = 3'd5;
    localparam logic [2:0] FN_RSVD6 = 3'd6;
    localparam logic [2:0] FN_RSVD7 = 3'd7;
    localparam int Q = FRAC_BITS_DEF;
    localparam int PHASE_ITEMS = 430;
    localparam int HOLD_CYCLES = 400;
    localparam int STALL_LIMIT = 20000;
    localparam int DRAIN_CYCLES = 150;
    localparam logic signed [127:0] SAT_HI = 128'sd2147483647;
    localparam logic signed [127:0] SAT_LO = -128'sd2147483648;

    typedef struct {
        t_in  op;
        bit   typed;
        t_out want;
    } t_row;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;

    cau_if #(.t_payload(t_in))  in_ch ();
    cau_if #(.t_payload(t_out)) out_ch ();

    complex_arithmetic_unit DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    always #5 i_clk = ~i_clk;

    t_out result_q[$];
    t_row rows[$];
    int   errors = 0;
    int   tx_idle = 0;
    int   rx_idle = 0;
    int   hold_seq = 0;
    int   hold_seen = 0;
    int   hold_cnt = 0;
    int   quiet_cycles = 0;

    // Clamp to 32 bits; bit 32 flags saturation.
    function automatic logic [32:0] clamp32(input logic signed [127:0] v);
        if (v > SAT_HI) return {1'b1, 32'h7FFF_FFFF};
        if (v < SAT_LO) return {1'b1, 32'h8000_0000};
        return {1'b0, v[31:0]};
    endfunction

    function automatic logic signed [127:0] wide(input logic [31:0] w);
        return {{96{w[31]}}, w};
    endfunction

    function automatic logic signed [127:0] quot(input logic signed [127:0] num,
                                                 input logic [127:0] den);
        logic [127:0] m;
        logic [127:0] qm;
        m = (num < 0) ? -num : num;
        qm = (m << Q) / den;
        return (num < 0) ? -$signed(qm) : $signed(qm);
    endfunction

    function automatic t_out cplx_eval(input t_in x);
        logic signed [127:0] ar, ai, br, bi, den;
        logic [32:0] cr, ci;
        t_out r;
        ar = wide(x.a_re);
        ai = wide(x.a_im);
        br = wide(x.b_re);
        bi = wide(x.b_im);
        cr = '0;
        ci = '0;
        r.status = ST_OK;
        case (x.func)
            FN_ADD: begin
                cr = clamp32(ar + br);
                ci = clamp32(ai + bi);
            end
            FN_SUB: begin
                cr = clamp32(ar - br);
                ci = clamp32(ai - bi);
            end
            FN_MUL: begin
                cr = clamp32((ar * br - ai * bi) >>> Q);
                ci = clamp32((ar * bi + ai * br) >>> Q);
            end
            FN_DIV: begin
                den = br * br + bi * bi;
                if (den == 0) begin
                    r.status = ST_DIVZ;
                end else begin
                    cr = clamp32(quot(ar * br + ai * bi, den));
                    ci = clamp32(quot(ai * br - ar * bi, den));
                end
            end
            FN_MAG: cr = clamp32((ar * ar + ai * ai) >>> Q);
            default: ;
        endcase
        if (r.status == ST_OK && (cr[32] || ci[32])) r.status = ST_OVF;
        r.res_re = cr[31:0];
        r.res_im = ci[31:0];
        return r;
    endfunction

    function automatic t_in mk(input logic [2:0] f, input logic [31:0] a_r,
                               input logic [31:0] a_i, input logic [31:0] b_r,
                               input logic [31:0] b_i);
        t_in x;
        x.func = f;
        x.a_re = a_r;
        x.a_im = a_i;
        x.b_re = b_r;
        x.b_im = b_i;
        return x;
    endfunction

    function automatic t_out res(input logic [31:0] r, input logic [31:0] i,
                                 input t_status s);
        t_out o;
        o.res_re = r;
        o.res_im = i;
        o.status = s;
        return o;
    endfunction

    function automatic logic [31:0] rand_word();
        logic [31:0] m;
        case ($urandom_range(7))
            0: return 32'h7FFF_FFFF;
            1: return 32'h8000_0000;
            2: return 32'h0;
            3, 4: begin
                m = $urandom_range(0, 32'h0010_0000);
                return $urandom_range(1) ? -m : m;
            end
            default: return $urandom;
        endcase
    endfunction

    function automatic t_in rand_item();
        t_in x;
        x = mk(($urandom_range(19) == 0) ? 3'($urandom_range(5, 7)) : 3'($urandom_range(4)),
               rand_word(), rand_word(), rand_word(), rand_word());
        if (x.func == FN_DIV && $urandom_range(15) == 0) begin
            x.b_re = '0;
            x.b_im = '0;
        end
        return x;
    endfunction

    // Offer one item, holding it until accepted.
    task automatic send(input t_in x, input bit typed, input t_out want);
        while (tx_idle > 0 && $urandom_range(99) < tx_idle) begin
            in_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        in_ch.valid <= 1'b1;
        in_ch.data  <= x;
        @(posedge i_clk);
        while (!in_ch.ready) @(posedge i_clk);
        result_q.push_back(typed ? want : cplx_eval(x));
    endtask

    task automatic drain();
        in_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (result_q.size() != 0) @(posedge i_clk);
    endtask

    always @(posedge i_clk) begin
        if (hold_seq != hold_seen) begin
            hold_seen <= hold_seq;
            hold_cnt  <= HOLD_CYCLES;
            out_ch.ready <= 1'b0;
        end else if (hold_cnt > 0) begin
            hold_cnt <= hold_cnt - 1;
            out_ch.ready <= 1'b0;
        end else begin
            out_ch.ready <= ($urandom_range(99) >= rx_idle);
        end
    end

    always @(posedge i_clk) begin
        t_out exp_r;
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            if (result_q.size() == 0) begin
                $display("%0t: unexpected result re=%h im=%h st=%0d", $time,
                         out_ch.data.res_re, out_ch.data.res_im, out_ch.data.status);
                errors++;
            end else begin
                exp_r = result_q.pop_front();
                if (out_ch.data.res_re !== exp_r.res_re) begin
                    $display("%0t: res_re expected %h got %h", $time,
                             exp_r.res_re, out_ch.data.res_re);
                    errors++;
                end
                if (out_ch.data.res_im !== exp_r.res_im) begin
                    $display("%0t: res_im expected %h got %h", $time,
                             exp_r.res_im, out_ch.data.res_im);
                    errors++;
                end
                if (out_ch.data.status !== exp_r.status) begin
                    $display("%0t: status expected %0d got %0d", $time,
                             exp_r.status, out_ch.data.status);
                    errors++;
                end
            end
        end
    end

    // Watchdog on cycles with no item moving on either side.
    always @(posedge i_clk) begin
        if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("FAIL");
            $finish;
        end
    end

    initial begin
        in_ch.valid  = 1'b0;
        in_ch.data   = '0;
        out_ch.ready = 1'b0;
        rows.push_back('{mk(FN_ADD, 0, 0, 0, 0), 1, res(0, 0, ST_OK)});
        rows.push_back('{mk(FN_ADD, 32'h7FFF_FFFF, 0, 32'h7FFF_FFFF, 0), 1,
                         res(32'h7FFF_FFFF, 0, ST_OVF)});
        rows.push_back('{mk(FN_SUB, 32'h8000_0000, 0, 1, 0), 1,
                         res(32'h8000_0000, 0, ST_OVF)});
        rows.push_back('{mk(FN_DIV, 32'h1_0000, 32'h1_0000, 0, 0), 1, res(0, 0, ST_DIVZ)});
        rows.push_back('{mk(FN_RSVD7, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                            32'hFFFF_FFFF), 1, res(0, 0, ST_OK)});
        rows.push_back('{mk(FN_MAG, 32'h8000_0000, 32'h8000_0000, 0, 0), 1,
                         res(32'h7FFF_FFFF, 0, ST_OVF)});
        rows.push_back('{mk(FN_RSVD5, 5, 6, 7, 8), 0, res(0, 0, ST_OK)});
        rows.push_back('{mk(FN_RSVD6, 32'h8000_0000, 1, 2, 3), 0, res(0, 0, ST_OK)});
        rows.push_back('{mk(FN_SUB, 32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000,
                            32'h7FFF_FFFF), 0, res(0, 0, ST_OK)});
        rows.push_back('{mk(FN_MUL, 32'h1_0000, 0, 32'h1_0000, 0), 0, res(0, 0, ST_OK)});
        rows.push_back('{mk(FN_MUL, 32'hFFFF_FFFF, 0, 1, 0), 0, res(0, 0, ST_OK)});
        rows.push_back('{mk(FN_MUL, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                            32'h7FFF_FFFF), 0, res(0, 0, ST_OK)});
        rows.push_back('{mk(FN_MUL, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                            32'h8000_0000), 0, res(0, 0, ST_OK)});
        rows.push_back('{mk(FN_DIV, 32'h1_0000, 0, 32'h1_0000, 0), 0, res(0, 0, ST_OK)});
        rows.push_back('{mk(FN_DIV, 32'hFFFF_0000, 32'h3_0000, 0, 32'h2_0000), 0,
                         res(0, 0, ST_OK)});
        rows.push_back('{mk(FN_DIV, 32'h7FFF_FFFF, 32'h8000_0000, 0, 1), 0, res(0, 0, ST_OK)});
        rows.push_back('{mk(FN_DIV, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                            32'h8000_0000), 0, res(0, 0, ST_OK)});
        rows.push_back('{mk(FN_DIV, 1, 32'hFFFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF), 0,
                         res(0, 0, ST_OK)});
        rows.push_back('{mk(FN_MAG, 32'h3_0000, 32'hFFFC_0000, 9, 9), 0, res(0, 0, ST_OK)});
        rows.push_back('{mk(FN_MAG, 32'hFFFF_FFFF, 1, 0, 0), 0, res(0, 0, ST_OK)});

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (rows[k]) send(rows[k].op, rows[k].typed, rows[k].want);
        // Pause the sender until the pipeline is empty.
        drain();

        for (int phase = 0; phase < 3; phase++) begin
            tx_idle = (phase == 0) ? 24 : (phase == 1) ? 69 : 0;
            rx_idle = (phase == 0) ? 69 : (phase == 1) ? 24 : 0;
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                if (phase == 2 && n == 100) hold_seq++;
                send(rand_item(), 0, res(0, 0, ST_OK));
            end
            drain();
        end

        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (errors == 0 && result_q.size() == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end
endmodule
